### hw/rtl/ips_pkg.sv
// Shared types and constants for the incremental PID step block.
// Holds the channel payload structs, item kinds and register indexes.
// No dependencies.
package ips_pkg;

   localparam int unsigned SAMPLE_WIDTH    = 16;
   localparam int unsigned GAIN_WIDTH      = 16;
   localparam int unsigned OUT_WIDTH       = 32;
   localparam int unsigned KIND_WIDTH      = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_UPDATE = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_RESET  = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_P_TARGET   = 2'd0,
      CSR_GAIN_P_MEASURE  = 2'd1,
      CSR_GAIN_INTEGRAL   = 2'd2,
      CSR_GAIN_DERIVATIVE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]          kind;
      logic signed [SAMPLE_WIDTH-1:0] target;
      logic signed [SAMPLE_WIDTH-1:0] measurement;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] delta_output;
      logic signed [OUT_WIDTH-1:0] delta_i;
   } rsp_type;

endpackage

### hw/rtl/incremental_pid_step_top.sv
// Incremental (velocity-form) PID step: input register, one combinational pass
// through the gain multiplies, adder tree and clamp, then the result register.
// Depends on ips_pkg.
//
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries one item per
//   transfer: a kind (update, record, reset), a target and a measurement.
//   Every item gives exactly one result on the response channel (rsp_valid,
//   rsp_stall, rsp_data): the held delta and the integral term taken on the
//   updated history.
//   An item taken moves from the input register to the result register, which
//   drives rsp_valid, once that is empty or draining. One item is taken every
//   cycle while req_stall is low; the five gain multiplies, the adder tree and
//   the clamp sit in the single pass between the input and result registers.
//   When the receiver stalls, the result register holds its payload and the
//   input register fills; req_stall rises only once both are full and
//   rsp_stall is high.
//   Gains are written through csr_write_enable, csr_index and csr_write_data.
//   The user writes them only while no item is in flight; the block trusts this.
//   Synchronous reset clears the gains, the sample history, the held delta
//   and both valid flags; the block takes items in the cycle after reset.
module incremental_pid_step_top #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  ips_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output ips_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_write_enable,
   input  logic [ips_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ips_pkg::GAIN_WIDTH-1:0]         csr_write_data
);

   localparam int unsigned SW     = ips_pkg::SAMPLE_WIDTH;
   localparam int unsigned GW     = ips_pkg::GAIN_WIDTH;
   localparam int unsigned OW     = ips_pkg::OUT_WIDTH;
   localparam int unsigned DIFF_W = SW + 2;
   localparam int unsigned PROD_W = DIFF_W + GW + 1;
   localparam int unsigned ACC_W  = PROD_W + 2;

   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-OW+1){1'b0}}, {(OW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-OW+1){1'b1}}, {(OW-1){1'b0}}};

   function automatic logic signed [OW-1:0] sat_out(input logic signed [ACC_W-1:0] v);
      logic signed [OW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[OW-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[OW-1:0];
      end else begin
         r = v[OW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [PROD_W-1:0] gain_mul(input logic [GW-1:0] g,
                                                         input logic signed [DIFF_W-1:0] d);
      logic signed [GW:0] gs;
      gs = $signed({1'b0, g});
      return PROD_W'(gs) * PROD_W'(d);
   endfunction

   // Gain registers
   logic [GW-1:0] gain_p_target_ff, gain_p_measure_ff, gain_integral_ff, gain_derivative_ff;

   // History
   logic signed [SW-1:0] last_target_ff, last_target_in;
   logic signed [SW-1:0] prev_meas_ff, prev_meas_in;
   logic signed [SW-1:0] prev_prev_meas_ff, prev_prev_meas_in;
   logic signed [OW-1:0] held_delta_ff, held_delta_in;

   // Input and result registers
   logic                      in_valid_ff;
   ips_pkg::req_type          in_data_ff;
   logic signed [PROD_W-1:0]  prod_pt, prod_pm, prod_i, prod_d, prod_di;
   logic                      rsp_valid_ff;
   ips_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic req_take, rsp_load;

   assign rsp_load  = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !rsp_load;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_target_ff   <= '0;
         gain_p_measure_ff  <= '0;
         gain_integral_ff   <= '0;
         gain_derivative_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (ips_pkg::csr_index_type'(csr_index))
            ips_pkg::CSR_GAIN_P_TARGET:   gain_p_target_ff   <= csr_write_data;
            ips_pkg::CSR_GAIN_P_MEASURE:  gain_p_measure_ff  <= csr_write_data;
            ips_pkg::CSR_GAIN_INTEGRAL:   gain_integral_ff   <= csr_write_data;
            ips_pkg::CSR_GAIN_DERIVATIVE: gain_derivative_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Differences against the history, history update and gain multiplies.
   logic signed [DIFF_W-1:0] tgt_x, meas_x, last_x, prev_x, pp_x;
   logic signed [DIFF_W-1:0] d_tgt, d_meas, err, d2, di_diff;

   always_comb begin
      tgt_x   = DIFF_W'(in_data_ff.target);
      meas_x  = DIFF_W'(in_data_ff.measurement);
      last_x  = DIFF_W'(last_target_ff);
      prev_x  = DIFF_W'(prev_meas_ff);
      pp_x    = DIFF_W'(prev_prev_meas_ff);
      d_tgt   = tgt_x - last_x;
      d_meas  = meas_x - prev_x;
      err     = tgt_x - meas_x;
      d2      = meas_x - (prev_x <<< 1) + pp_x;

      last_target_in    = last_target_ff;
      prev_meas_in      = prev_meas_ff;
      prev_prev_meas_in = prev_prev_meas_ff;
      unique case (in_data_ff.kind)
         ips_pkg::KIND_UPDATE, ips_pkg::KIND_RECORD: begin
            last_target_in    = in_data_ff.target;
            prev_prev_meas_in = prev_meas_ff;
            prev_meas_in      = in_data_ff.measurement;
         end
         ips_pkg::KIND_RESET: begin
            last_target_in = '0;
            prev_meas_in   = '0;
         end
         default: ;
      endcase

      di_diff = DIFF_W'(last_target_in) - DIFF_W'(prev_meas_in);
      prod_pt = gain_mul(gain_p_target_ff, d_tgt);
      prod_pm = gain_mul(gain_p_measure_ff, d_meas);
      prod_i  = gain_mul(gain_integral_ff, err);
      prod_d  = gain_mul(gain_derivative_ff, d2);
      prod_di = gain_mul(gain_integral_ff, di_diff);
   end

   // Adder tree, floor shift, clamp.
   logic signed [ACC_W-1:0] acc, acc_shift, di_shift;

   always_comb begin
      acc       = ACC_W'(prod_pt) - ACC_W'(prod_pm) + ACC_W'(prod_i) + ACC_W'(prod_d);
      acc_shift = acc >>> FRAC_BITS;
      di_shift  = ACC_W'(prod_di) >>> FRAC_BITS;

      held_delta_in = held_delta_ff;
      unique case (in_data_ff.kind)
         ips_pkg::KIND_UPDATE: held_delta_in = sat_out(acc_shift);
         ips_pkg::KIND_RESET:  held_delta_in = '0;
         default: ;
      endcase

      rsp_data_in.delta_output = held_delta_in;
      rsp_data_in.delta_i      = sat_out(di_shift);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         last_target_ff    <= '0;
         prev_meas_ff      <= '0;
         prev_prev_meas_ff <= '0;
         held_delta_ff     <= '0;
      end else begin
         if (req_take || rsp_load) begin
            in_valid_ff <= req_take;
         end
         if (rsp_load || (rsp_valid_ff && !rsp_stall)) begin
            rsp_valid_ff <= rsp_load;
         end
         // History moves with the transfer into the result register, so the
         // next item in the input register already sees it.
         if (rsp_load) begin
            last_target_ff    <= last_target_in;
            prev_meas_ff      <= prev_meas_in;
            prev_prev_meas_ff <= prev_prev_meas_in;
            held_delta_ff     <= held_delta_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### hw/rtl/ips_checker.sv
// Port-level checks for the incremental PID step block.
// Depends on ips_pkg; bound to incremental_pid_step_top below.
module ips_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ips_pkg::rsp_type rsp_data
);

   // A cycle of reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The input side backs up only when the result side is holding a result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result side is free");

   // A stalled result stays in place.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

   // A request is never refused while no result is waiting.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !rsp_valid) |-> !req_stall)
      else $error("request refused with an empty result register");

endmodule

bind incremental_pid_step_top ips_checker u_ips_checker (.*);
